// ===== rtl/ttps_pkg.sv =====
package ttps_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PLATE_CONFIGURED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MINUTE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_MINUTE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_SECONDS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD     = 3'd4;

	localparam logic [10:0] START_MINUTE_RST  = 11'd0;
	localparam logic [10:0] END_MINUTE_RST    = 11'd1439;
	localparam logic [7:0]  PHASE_SECONDS_RST = 8'd6;
	localparam logic [5:0]  CHECK_PERIOD_RST  = 6'd6;

	localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;
	// floor(x / 15) == (x * 2185) >> 15 for every x below 2048.
	localparam logic [22:0] DIV15_MUL   = 23'd2185;
	localparam int          DIV15_SHIFT = 15;

	localparam logic [7:0] ELAPSED_MAX = 8'hFF;

	// Reported step phase codes.
	localparam logic [1:0] STEP_STABLE = 2'd0;
	localparam logic [1:0] STEP_FIRST  = 2'd1;
	localparam logic [1:0] STEP_SECOND = 2'd2;

	typedef enum logic [2:0] {
		PH_STABLE = 3'b001,
		PH_FIRST  = 3'b010,
		PH_SECOND = 3'b100
	} phase_t;

	typedef struct packed {
		logic       command;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       time_confirmed;
		logic       manual_hold;
		logic [5:0] new_position;
	} in_item_t;

	typedef struct packed {
		logic       relay_even;
		logic       relay_odd;
		logic [5:0] cur_position;
		logic [1:0] step_phase;
		logic [5:0] target_position;
		logic       in_sync;
	} out_item_t;

	typedef struct packed {
		logic        plate_configured;
		logic [10:0] start_minute;
		logic [10:0] end_minute;
		logic [7:0]  phase_seconds;
		logic [63:0] check_mask;
	} cfg_t;

	// Bit s is set when second s is a multiple of the period; a zero period acts as one.
	function automatic logic [63:0] period_mask(input logic [5:0] period);
		logic [63:0] mask;
		logic [5:0]  eff;
		logic [11:0] prod;
		mask = '0;
		eff = (period == 6'd0) ? 6'd1 : period;
		for (int k = 0; k < 64; k++) begin
			prod = 12'(k) * {6'd0, eff};
			if (prod < 12'd64) begin
				mask[prod[5:0]] = 1'b1;
			end
		end
		return mask;
	endfunction

	localparam logic [63:0] CHECK_MASK_RST = period_mask(CHECK_PERIOD_RST);

endpackage

// ===== rtl/ttps_target.sv =====
module ttps_target #(
	parameter int POSITIONS = 64,
	parameter int PW        = $clog2(POSITIONS)
) (
	input  ttps_pkg::cfg_t   cfg,
	input  logic [4:0]       hour,
	input  logic [5:0]       minute,
	output logic [PW-1:0]    target
);
	import ttps_pkg::*;

	localparam logic [PW-1:0] NIGHT = PW'(POSITIONS - 1);

	logic [10:0] total;
	logic [10:0] diff;
	logic [22:0] prod;
	logic [7:0]  quot;
	logic        outside;

	assign total   = 11'(hour) * MINUTES_PER_HOUR + 11'(minute);
	assign diff    = total - cfg.start_minute;
	assign prod    = 23'(diff) * DIV15_MUL;
	assign quot    = prod[DIV15_SHIFT +: 8];
	assign outside = !cfg.plate_configured || (total < cfg.start_minute)
		|| (total > cfg.end_minute);

	always_comb begin
		if (outside || ({1'b0, quot} > 9'(POSITIONS - 1))) begin
			target = NIGHT;
		end else begin
			target = PW'(quot);
		end
	end

endmodule

// ===== rtl/ttps_stepper.sv =====
module ttps_stepper #(
	parameter int POSITIONS = 64,
	parameter int PW        = $clog2(POSITIONS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ttps_pkg::in_item_t  item,
	input  ttps_pkg::cfg_t      cfg,
	input  logic [PW-1:0]       target,
	output ttps_pkg::out_item_t result
);
	import ttps_pkg::*;

	localparam logic [PW-1:0] LAST_POS = PW'(POSITIONS - 1);

	logic [PW-1:0] pos_q, pos_d, pos_inc, newpos_sat;
	phase_t        ph_q, ph_d;
	logic [7:0]    el_q, el_d, el_inc;
	logic          chk;
	logic          confirmed;

	assign confirmed  = item.time_confirmed;
	assign pos_inc    = (pos_q == LAST_POS) ? '0 : pos_q + PW'(1);
	assign el_inc     = (el_q == ELAPSED_MAX) ? el_q : el_q + 8'd1;
	assign newpos_sat = ({3'b000, item.new_position} > 9'(POSITIONS - 1)) ? LAST_POS
		: PW'(item.new_position);

	always_comb begin
		pos_d = pos_q;
		ph_d  = ph_q;
		el_d  = el_q;
		chk   = 1'b0;
		if (item.command) begin
			pos_d = newpos_sat;
			ph_d  = PH_STABLE;
			el_d  = '0;
		end else if (!confirmed || item.manual_hold) begin
			ph_d = PH_STABLE;
			el_d = '0;
		end else if (ph_q != PH_STABLE) begin
			el_d = el_inc;
			if (el_inc >= cfg.phase_seconds) begin
				if (ph_q == PH_FIRST) begin
					ph_d = PH_SECOND;
					el_d = '0;
				end else begin
					// Step done; the next step may start in the same second.
					pos_d = pos_inc;
					ph_d  = PH_STABLE;
					el_d  = '0;
					chk   = 1'b1;
				end
			end
		end else begin
			chk = 1'b1;
		end
		if (chk && cfg.check_mask[item.second] && (pos_d != target)) begin
			ph_d = PH_FIRST;
			el_d = '0;
		end
	end

	always_comb begin
		result.relay_even      = confirmed && (ph_d == PH_FIRST);
		result.relay_odd       = confirmed && (ph_d == PH_SECOND);
		result.cur_position    = 6'(pos_d);
		result.target_position = 6'(target);
		result.in_sync         = confirmed && (ph_d == PH_STABLE) && (pos_d == target);
		case (ph_d)
			PH_STABLE: result.step_phase = STEP_STABLE;
			PH_FIRST:  result.step_phase = STEP_FIRST;
			PH_SECOND: result.step_phase = STEP_SECOND;
			default:   result.step_phase = STEP_STABLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ph_q  <= PH_STABLE;
			el_q  <= '0;
		end else if (en) begin
			pos_q <= pos_d;
			ph_q  <= ph_d;
			el_q  <= el_d;
		end
	end

endmodule

// ===== rtl/time_tracking_plate_stepper.sv =====
// A request accepted into the input register has its result computed from that
// register and captured in the result register when the output can take it.
// Throughput: one request per cycle unless the output stalls; the input register
// and the result register are both refilled in the same cycle the result is taken.
// Reset (arst_n low) clears plate position, step phase, elapsed count, both
// valid flags and the configuration registers to their defaults at once.
module time_tracking_plate_stepper #(
	parameter int POSITIONS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ttps_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ttps_pkg::out_item_t                out_data,
	input  logic                               cfg_wr_en,
	input  logic [ttps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ttps_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ttps_pkg::*;

	localparam int PW = $clog2(POSITIONS);

	cfg_t       cfg_q;
	logic       in_valid_s1;
	in_item_t   in_data_s1;
	logic       out_valid_s2;
	out_item_t  out_data_s2;
	logic       advance;
	logic [PW-1:0] target;
	out_item_t  result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plate_configured <= 1'b0;
			cfg_q.start_minute     <= START_MINUTE_RST;
			cfg_q.end_minute       <= END_MINUTE_RST;
			cfg_q.phase_seconds    <= PHASE_SECONDS_RST;
			cfg_q.check_mask       <= CHECK_MASK_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PLATE_CONFIGURED: cfg_q.plate_configured <= cfg_data[0];
				REG_START_MINUTE:     cfg_q.start_minute     <= cfg_data;
				REG_END_MINUTE:       cfg_q.end_minute       <= cfg_data;
				REG_PHASE_SECONDS:    cfg_q.phase_seconds    <= cfg_data[7:0];
				REG_CHECK_PERIOD:     cfg_q.check_mask       <= period_mask(cfg_data[5:0]);
				default: ;
			endcase
		end
	end

	assign advance  = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				in_valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_data_s1 <= in_data;
		end
		if (advance) begin
			out_data_s2 <= result;
		end
	end

	ttps_target #(
		.POSITIONS(POSITIONS),
		.PW       (PW)
	) u_target (
		.cfg   (cfg_q),
		.hour  (in_data_s1.hour),
		.minute(in_data_s1.minute),
		.target(target)
	);

	ttps_stepper #(
		.POSITIONS(POSITIONS),
		.PW       (PW)
	) u_stepper (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.item  (in_data_s1),
		.cfg   (cfg_q),
		.target(target),
		.result(result)
	);

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

endmodule

// ===== rtl/ttps_checker.sv =====
module ttps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input ttps_pkg::out_item_t             out_data
);
	import ttps_pkg::*;

	// A result that waits for the consumer stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// The two relays never drive together.
	a_relay_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.relay_even && out_data.relay_odd))
		else $error("both relays on");

	// A relay on means the matching step phase is reported.
	a_relay_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.relay_even || out_data.relay_odd) |->
		(out_data.relay_even && out_data.step_phase == STEP_FIRST) ||
		(out_data.relay_odd && out_data.step_phase == STEP_SECOND))
		else $error("relay and phase disagree");

	// In sync implies a stable plate sitting on its target.
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_sync |->
		out_data.step_phase == STEP_STABLE &&
		out_data.cur_position == out_data.target_position)
		else $error("in_sync while moving or off target");

	// With no result waiting the block always takes a new request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

endmodule

bind time_tracking_plate_stepper ttps_checker u_ttps_checker (.*);

// ===== tb/plate_tb_pkg.sv =====
`timescale 1ns / 100ps
package plate_tb_pkg;

	// Request kinds carried in the command field.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

endpackage

// ===== tb/plate_step_checker.sv =====
`timescale 1ns / 100ps
module plate_step_checker
	import ttps_pkg::*;
	import plate_tb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  in_item_t                in_data,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  out_item_t               out_data,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output int                      fail_count,
	output int                      outstanding
);

	localparam logic [5:0] NIGHT_POSITION   = 6'd63;
	localparam int         MINUTES_PER_SLOT = 15;

	// Shadow copy of the configuration registers.
	logic        cfg_configured;
	logic [10:0] cfg_start;
	logic [10:0] cfg_end;
	logic [7:0]  cfg_phase_len;
	logic [5:0]  cfg_period;

	// Predicted plate state.
	logic [5:0] plate_pos;
	logic [1:0] step_ph;
	logic [7:0] phase_count;

	out_item_t expected_plate_q[$];
	out_item_t want_res;
	int        result_count;

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("plate mismatch %0d at %0t: %s", fail_count, $time, what);
	endtask

	task automatic compare_field(input string name, input logic [5:0] got,
			input logic [5:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d field %s: got %0d, want %0d",
				result_count, name, got, want));
	endtask

	function automatic logic [5:0] target_of(input logic [4:0] hr, input logic [5:0] mn);
		int total;
		int slot;
		total = int'(hr) * int'(MINUTES_PER_HOUR) + int'(mn);
		if (!cfg_configured || total < int'(cfg_start) || total > int'(cfg_end))
			return NIGHT_POSITION;
		slot = (total - int'(cfg_start)) / MINUTES_PER_SLOT;
		return (slot > int'(NIGHT_POSITION)) ? NIGHT_POSITION : 6'(slot);
	endfunction

	function automatic void maybe_start_step(input logic [5:0] sec, input logic [5:0] tgt);
		logic [5:0] period;
		period = (cfg_period == 6'd0) ? 6'd1 : cfg_period;
		if (step_ph == STEP_STABLE && (sec % period) == 6'd0 && plate_pos != tgt) begin
			step_ph = STEP_FIRST;
			phase_count = '0;
		end
	endfunction

	function automatic out_item_t predict_plate_step(input in_item_t req);
		out_item_t res;
		logic [5:0] tgt;
		tgt = target_of(req.hour, req.minute);
		if (req.command == CMD_SET) begin
			// A 6-bit position can never exceed the night position, so no clamp is needed.
			plate_pos = req.new_position;
			step_ph = STEP_STABLE;
			phase_count = '0;
		end else if (!req.time_confirmed || req.manual_hold) begin
			step_ph = STEP_STABLE;
			phase_count = '0;
		end else if (step_ph != STEP_STABLE) begin
			if (phase_count != ELAPSED_MAX)
				phase_count++;
			if (phase_count >= cfg_phase_len) begin
				if (step_ph == STEP_FIRST) begin
					step_ph = STEP_SECOND;
					phase_count = '0;
				end else begin
					plate_pos = plate_pos + 6'd1;
					step_ph = STEP_STABLE;
					phase_count = '0;
					// A finished step may start the next one on the same tick.
					maybe_start_step(req.second, tgt);
				end
			end
		end else begin
			maybe_start_step(req.second, tgt);
		end

		res = '0;
		if (req.time_confirmed) begin
			res.relay_even = (step_ph == STEP_FIRST);
			res.relay_odd = (step_ph >= STEP_SECOND);
			res.in_sync = (step_ph == STEP_STABLE) && (plate_pos == tgt);
		end
		res.cur_position = plate_pos;
		res.step_phase = step_ph;
		res.target_position = tgt;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_configured = 1'b0;
			cfg_start = START_MINUTE_RST;
			cfg_end = END_MINUTE_RST;
			cfg_phase_len = PHASE_SECONDS_RST;
			cfg_period = CHECK_PERIOD_RST;
			plate_pos = '0;
			step_ph = STEP_STABLE;
			phase_count = '0;
			expected_plate_q.delete();
			result_count = 0;
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_plate_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no request pending",
						result_count));
				end else begin
					want_res = expected_plate_q.pop_front();
					compare_field("relay_even", 6'(out_data.relay_even), 6'(want_res.relay_even));
					compare_field("relay_odd", 6'(out_data.relay_odd), 6'(want_res.relay_odd));
					compare_field("position", out_data.cur_position,
						want_res.cur_position);
					compare_field("step_phase", 6'(out_data.step_phase), 6'(want_res.step_phase));
					compare_field("target_position", out_data.target_position,
						want_res.target_position);
					compare_field("in_sync", 6'(out_data.in_sync), 6'(want_res.in_sync));
				end
			end
			if (in_valid && in_ready)
				expected_plate_q.push_back(predict_plate_step(in_data));
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PLATE_CONFIGURED: cfg_configured = cfg_data[0];
					REG_START_MINUTE: cfg_start = cfg_data[10:0];
					REG_END_MINUTE: cfg_end = cfg_data[10:0];
					REG_PHASE_SECONDS: cfg_phase_len = cfg_data[7:0];
					REG_CHECK_PERIOD: cfg_period = cfg_data[5:0];
					default: ;
				endcase
			end
			outstanding <= expected_plate_q.size();
		end
	end

endmodule

// ===== tb/tb_time_tracking_plate_stepper.sv =====
`timescale 1ns / 100ps
module tb_time_tracking_plate_stepper;
	import ttps_pkg::*;
	import plate_tb_pkg::*;

	localparam int CYCLE_LIMIT     = 250000;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int RX_HOLD_CYCLES  = 250;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    outstanding;

	int cycles;
	bit rx_hold_req;
	bit tx_quiet;
	int sent_count;

	// Wall-clock time that the random ticks walk through.
	int cur_h;
	int cur_m;
	int cur_s;
	int win_lo;
	int win_hi;

	time_tracking_plate_stepper #(.POSITIONS(64)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	plate_step_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic in_item_t build_request(input logic cmd, input int h, input int m,
			input int s, input int conf, input int hold, input int np);
		in_item_t req;
		req.command = cmd;
		req.hour = 5'(h);
		req.minute = 6'(m);
		req.second = 6'(s);
		req.time_confirmed = (conf != 0);
		req.manual_hold = (hold != 0);
		req.new_position = 6'(np);
		return req;
	endfunction

	// Offers one request after a random gap and returns at the edge that takes it.
	task automatic send_request(input in_item_t req);
		int gap;
		if (sent_count % 60 == 0)
			tx_quiet = ($urandom_range(0, 3) == 0);
		gap = tx_quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	// Stops offering and waits until every result has come back.
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_settings(input int configured, input int start_m, input int end_m,
			input int phase_len, input int period);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_PLATE_CONFIGURED;
		cfg_data <= CFG_DATA_W'(configured);
		@(posedge clk);
		cfg_index <= REG_START_MINUTE;
		cfg_data <= CFG_DATA_W'(start_m);
		@(posedge clk);
		cfg_index <= REG_END_MINUTE;
		cfg_data <= CFG_DATA_W'(end_m);
		@(posedge clk);
		cfg_index <= REG_PHASE_SECONDS;
		cfg_data <= CFG_DATA_W'(phase_len);
		@(posedge clk);
		cfg_index <= REG_CHECK_PERIOD;
		cfg_data <= CFG_DATA_W'(period);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (start_m <= end_m && start_m <= 1439) begin
			win_lo = (start_m > 30) ? start_m - 30 : 0;
			win_hi = (end_m + 30 < 1439) ? end_m + 30 : 1439;
		end else begin
			win_lo = 0;
			win_hi = 1439;
		end
	endtask

	function automatic void advance_clock;
		cur_s++;
		if (cur_s == 60) begin
			cur_s = 0;
			cur_m++;
		end
		if (cur_m == 60) begin
			cur_m = 0;
			cur_h = (cur_h + 1) % 24;
		end
	endfunction

	// Mostly consecutive confirmed ticks, with time jumps, set commands and raw noise mixed in.
	function automatic in_item_t random_request;
		int roll;
		int total;
		in_item_t req;
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			req = in_item_t'($urandom());
		end else if (roll < 9) begin
			req = build_request(CMD_SET, cur_h, cur_m, $urandom_range(0, 63),
				$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 63));
		end else begin
			if (roll < 15) begin
				total = $urandom_range(win_lo, win_hi);
				cur_h = total / 60;
				cur_m = total % 60;
				cur_s = $urandom_range(0, 59);
			end else begin
				advance_clock();
			end
			req = build_request(CMD_TICK, cur_h, cur_m, cur_s,
				int'(!(roll >= 15 && roll < 19)), int'(roll >= 19 && roll < 22),
				$urandom_range(0, 63));
		end
		return req;
	endfunction

	task automatic pick_settings(input int phase_idx);
		int st;
		case (phase_idx)
			0: write_settings(1, 0, 1439, 1, 1);
			1: write_settings(1, 600, 700, 2, 5);
			2: write_settings(0, 0, 1439, 0, 0);
			3: write_settings(1, 1439, 0, 3, 59);
			4: write_settings(1, 2047, 2047, 255, 63);
			default: begin
				st = $urandom_range(0, 1200);
				write_settings(int'($urandom_range(0, 3) != 0), st, $urandom_range(st, 1439),
					$urandom_range(1, 4), $urandom_range(1, 10));
			end
		endcase
	endtask

	// Result side: a random stall before each result, quiet stretches, and one long hold-off.
	initial begin
		int stall;
		int taken;
		bit rx_quiet;
		bit hold_done;
		out_ready = 1'b0;
		taken = 0;
		rx_quiet = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 50 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			stall = rx_quiet ? 0 : $urandom_range(0, 13);
			if (rx_hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall = RX_HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rx_hold_req = 1'b0;
		tx_quiet = 1'b0;
		sent_count = 0;
		cur_h = 0;
		cur_m = 0;
		cur_s = 0;
		win_lo = 0;
		win_hi = 1439;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: plate not configured, so the target is the night position.
		send_request(build_request(CMD_SET, 23, 59, 59, 1, 0, 63));
		send_request(build_request(CMD_TICK, 23, 59, 0, 1, 0, 0));
		send_request(build_request(CMD_SET, 0, 0, 0, 0, 0, 0));
		send_request(build_request(CMD_TICK, 0, 0, 1, 1, 0, 0));
		send_request(build_request(CMD_TICK, 0, 0, 6, 1, 0, 0));
		send_request(build_request(CMD_TICK, 0, 0, 7, 1, 1, 0));
		send_request(build_request(CMD_TICK, 0, 0, 12, 1, 0, 0));
		send_request(build_request(CMD_TICK, 0, 0, 13, 0, 0, 0));
		send_request(build_request(CMD_TICK, 0, 0, 18, 1, 0, 0));
		drain();

		// Full-day window, phase length of one, zero check period: steps run back to back.
		write_settings(1, 0, 1439, 1, 0);
		send_request(build_request(CMD_SET, 0, 30, 0, 1, 0, 63));
		send_request(build_request(CMD_TICK, 0, 30, 1, 1, 0, 0));
		send_request(build_request(CMD_TICK, 0, 30, 2, 1, 0, 0));
		send_request(build_request(CMD_TICK, 0, 30, 3, 1, 0, 0));
		send_request(build_request(CMD_TICK, 23, 0, 4, 1, 0, 0));
		send_request(build_request(CMD_TICK, 23, 59, 59, 1, 0, 0));
		send_request(build_request(CMD_SET, 1, 0, 0, 1, 0, 5));
		send_request(build_request(CMD_TICK, 1, 0, 5, 1, 0, 0));
		drain();

		// Top-end register values and a zero phase length; time fields beyond range.
		write_settings(1, 2047, 2047, 0, 63);
		send_request(build_request(CMD_SET, 31, 63, 63, 1, 1, 10));
		send_request(build_request(CMD_TICK, 31, 63, 0, 1, 0, 0));
		send_request(build_request(CMD_TICK, 31, 63, 63, 1, 0, 63));
		send_request(build_request(CMD_TICK, 31, 63, 63, 1, 0, 0));
		send_request(build_request(CMD_TICK, 31, 63, 0, 1, 0, 0));
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			pick_settings(p);
			if (p == 5)
				rx_hold_req = 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_request(random_request());
			drain();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
